[rtl/core/minmax_int8_quantizer_top_assert.svh]
// Assertion macros for the min/max int8 quantiser
`ifndef MINMAX_INT8_QUANTIZER_TOP_ASSERT_SVH
`define MINMAX_INT8_QUANTIZER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MMQ_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MMQ_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MMQ_ASSERT_SAME(label, clock, reset, ante, cons)
`define MMQ_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

[rtl/core/mmq_pkg.sv]
// Shared types and constants of the min/max int8 quantiser
package mmq_pkg;

  localparam int BUFFER_DEPTH = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int ADDR_BITS    = $clog2(BUFFER_DEPTH);
  localparam int COUNT_BITS   = $clog2(BUFFER_DEPTH + 1);
  localparam int CODE_BITS    = 8;
  localparam int CODE_MAX     = (1 << CODE_BITS) - 1;
  localparam int CODE_SCALE2  = 2 * CODE_MAX;
  localparam int NUM_BITS     = SAMPLE_BITS + CODE_BITS + 1;
  localparam int STEP_BITS    = $clog2(CODE_BITS);

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]          code;
    logic signed [SAMPLE_BITS-1:0] set_minimum;
    logic [SAMPLE_BITS-1:0]        set_span;
    logic                          final_code;
    logic                          samples_dropped;
  } out_t;

  typedef struct packed {
    logic load;
    logic drain;
    logic prep;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pending;
    logic div_last;
    logic out_full;
  } status_t;

endpackage

[rtl/core/mmq_ctrl.sv]
// Controller state machine of the min/max int8 quantiser
`include "minmax_int8_quantizer_top_assert.svh"

module mmq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             action,
  output logic             item_ready,
  input  mmq_pkg::status_t status,
  output mmq_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_DIV  = 5'b00100,
    S_DONE = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept && action == mmq_pkg::ACT_LOAD) begin
          cmd.load = 1'b1;
        end else if (accept && action == mmq_pkg::ACT_DRAIN && status.pending) begin
          cmd.drain  = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.out_full) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!status.out_full) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `MMQ_ASSERT_NEXT(a_div_to_done, clk, rst, state == S_DIV && status.div_last, state == S_DONE)
  `MMQ_ASSERT_SAME(a_finish_free, clk, rst, cmd.finish, !status.out_full)
  `MMQ_ASSERT_NEXT(a_drain_reads, clk, rst, cmd.drain, state == S_READ && !item_ready)

endmodule

[rtl/core/mmq_datapath.sv]
// Datapath: sample buffer, running min/max, numerator and restoring divider
`include "minmax_int8_quantizer_top_assert.svh"

module mmq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  mmq_pkg::cmd_t     cmd,
  input  mmq_pkg::in_t      item_data,
  input  logic              result_ready,
  output logic              result_valid,
  output mmq_pkg::out_t     result_data,
  output mmq_pkg::status_t  status
);

  logic signed [mmq_pkg::SAMPLE_BITS-1:0] mem [mmq_pkg::BUFFER_DEPTH];

  logic [mmq_pkg::COUNT_BITS-1:0]         load_count;
  logic [mmq_pkg::COUNT_BITS-1:0]         drain_index;
  logic signed [mmq_pkg::SAMPLE_BITS-1:0] running_min;
  logic signed [mmq_pkg::SAMPLE_BITS-1:0] running_max;
  logic                                   overflow_seen;

  logic signed [mmq_pkg::SAMPLE_BITS-1:0] rd_data;
  logic signed [mmq_pkg::SAMPLE_BITS-1:0] cap_min;
  logic [mmq_pkg::SAMPLE_BITS-1:0]        cap_span;
  logic                                   cap_last;
  logic                                   cap_ovf;

  logic [mmq_pkg::NUM_BITS-1:0]           rem;
  logic [mmq_pkg::NUM_BITS-1:0]           dvs_sh;
  logic [mmq_pkg::CODE_BITS-1:0]          quo;
  logic [mmq_pkg::STEP_BITS-1:0]          step_cnt;

  logic signed [mmq_pkg::SAMPLE_BITS-1:0] x;
  logic                                   full;
  logic                                   last;
  logic [mmq_pkg::SAMPLE_BITS-1:0]        span_now;
  logic [mmq_pkg::SAMPLE_BITS-1:0]        offs;
  logic [mmq_pkg::NUM_BITS-1:0]           num;
  logic                                   ge;

  assign x        = $signed(item_data.sample);
  assign full     = (load_count == mmq_pkg::COUNT_BITS'(mmq_pkg::BUFFER_DEPTH));
  assign last     = ((drain_index + mmq_pkg::COUNT_BITS'(1)) == load_count);
  assign span_now = mmq_pkg::SAMPLE_BITS'(running_max - running_min);
  assign offs     = mmq_pkg::SAMPLE_BITS'(rd_data - cap_min);
  assign num      = mmq_pkg::NUM_BITS'(offs) * mmq_pkg::NUM_BITS'(mmq_pkg::CODE_SCALE2)
                    + mmq_pkg::NUM_BITS'(cap_span);
  assign ge       = (rem >= dvs_sh);

  assign status.pending  = (drain_index < load_count);
  assign status.div_last = (step_cnt == '0);
  assign status.out_full = result_valid;

  // buffer
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[load_count[mmq_pkg::ADDR_BITS-1:0]] <= x;
    end
    if (cmd.drain) begin
      rd_data <= mem[drain_index[mmq_pkg::ADDR_BITS-1:0]];
    end
  end

  // set state
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count    <= '0;
      drain_index   <= '0;
      running_min   <= '0;
      running_max   <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          if (load_count == '0) begin
            running_min <= x;
            running_max <= x;
          end else begin
            if (x < running_min) running_min <= x;
            if (x > running_max) running_max <= x;
          end
          load_count <= load_count + mmq_pkg::COUNT_BITS'(1);
        end
      end
      if (cmd.drain) begin
        if (last) begin
          load_count    <= '0;
          drain_index   <= '0;
          running_min   <= '0;
          running_max   <= '0;
          overflow_seen <= 1'b0;
        end else begin
          drain_index <= drain_index + mmq_pkg::COUNT_BITS'(1);
        end
      end
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // drain capture and restoring division, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.drain) begin
      cap_min  <= running_min;
      cap_span <= span_now;
      cap_last <= last;
      cap_ovf  <= overflow_seen;
    end
    if (cmd.prep) begin
      rem      <= num;
      dvs_sh   <= mmq_pkg::NUM_BITS'({cap_span, 1'b0}) << (mmq_pkg::CODE_BITS - 1);
      step_cnt <= mmq_pkg::STEP_BITS'(mmq_pkg::CODE_BITS - 1);
    end
    if (cmd.div_step) begin
      if (ge) rem <= rem - dvs_sh;
      quo      <= {quo[mmq_pkg::CODE_BITS-2:0], ge};
      dvs_sh   <= dvs_sh >> 1;
      step_cnt <= step_cnt - mmq_pkg::STEP_BITS'(1);
    end
    if (cmd.finish) begin
      result_data.code            <= (cap_span == '0) ? '0 : quo;
      result_data.set_minimum     <= cap_min;
      result_data.set_span        <= cap_span;
      result_data.final_code      <= cap_last;
      result_data.samples_dropped <= cap_ovf;
    end
  end

  `MMQ_ASSERT_SAME(a_count_bound, clk, rst, 1'b1,
                   load_count <= mmq_pkg::COUNT_BITS'(mmq_pkg::BUFFER_DEPTH))
  `MMQ_ASSERT_SAME(a_drain_bound, clk, rst, 1'b1, drain_index <= load_count)
  `MMQ_ASSERT_NEXT(a_last_clears, clk, rst, cmd.drain && last,
                   drain_index == '0 && !overflow_seen)

endmodule

[rtl/core/minmax_int8_quantizer_top.sv]
// Top level of the min/max int8 quantiser: controller plus datapath
// Load beats store a signed Q8.8 sample (up to 1024 per set, later ones are dropped and
// flagged) and widen the running min/max. Drain beats return the stored samples in load
// order as unsigned codes round(255*(x-min)/span), half up, each with the set's minimum,
// span, a last-of-set mark and the drop flag; a drain goes through a buffer read, the
// numerator, eight restoring-division steps and the output register, which waits while
// the previous result is not yet taken; no new beat is accepted meanwhile. A drain with
// nothing left to give yields no result. Draining the last code starts a fresh set.
module minmax_int8_quantizer_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  mmq_pkg::in_t  item_data,
  output logic          result_valid,
  input  logic          result_ready,
  output mmq_pkg::out_t result_data
);

  mmq_pkg::cmd_t    cmd;
  mmq_pkg::status_t status;

  mmq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .action     (item_data.action),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  mmq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item_data    (item_data),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result_data  (result_data),
    .status       (status)
  );

endmodule
